@@ sv/gda_pkg.sv @@
// Package for the Gregorian date add-days core: widths, span constants, helpers.
// No dependencies.
`timescale 1ns / 1ps
package gda_pkg;
  localparam int unsigned DefaultMaxYear = 9999;
  localparam int DayW  = 5;
  localparam int MonW  = 4;
  localparam int YearW = 14;
  localparam int OffW  = 23;
  localparam int WdW   = 3;
  // day numbers stay within about 2^25 for any year up to 65535
  localparam int SumW  = 26;
  localparam int Days400 = 146097;
  localparam int Days100 = 36524;
  localparam int Days4   = 1461;
  localparam int Days1   = 365;

  // remainder by 7: octal digits fold since 8 leaves 1
  function automatic logic [2:0] mod7(input logic [SumW:0] x);
    logic [5:0] acc;
    logic [3:0] f;
    logic [3:0] g;
    acc = '0;
    for (int i = 0; i < 9; i++) acc = acc + 6'(x[3*i +: 3]);
    f = 4'(acc[5:3]) + 4'(acc[2:0]);
    g = 4'(f[3]) + 4'(f[2:0]);
    return (g == 4'd7) ? 3'd0 : g[2:0];
  endfunction

  // days in the year before the first of month m (1..12), non-leap
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction
endpackage

@@ sv/gregorian_date_add_days_core.sv @@
// Gregorian date add-days core: date to day number, add offset, back to date.
// Depends on gda_pkg and gda_split.
//
// Usage: present start_day, start_month, start_year and day_offset with
// in_valid; a transaction is taken when in_valid is high and in_stall low.
// The result (end_day, end_month, end_year, weekday, out_of_range) appears
// with out_valid and is taken when out_stall is low.
// The pipeline has 11 register stages; out_valid moves with the input
// transaction through them and holds with the data while out_stall is high.
// One transaction can enter every cycle while out_stall is low. The stages are: clamp,
// year quotient by 100, day number parts, sum and range check, 400-year
// quotient, 400-year remainder, the 100, 4 and 1 year splits, year, month.
// Out-of-range results carry zero date fields and weekday.
// Reset clears all valid bits; payload registers are not reset.
// When out_stall is high the whole pipeline holds and in_stall rises in the
// same cycle, so nothing is lost or repeated.
`timescale 1ns / 1ps
module gregorian_date_add_days_core #(
  parameter int unsigned MAX_YEAR = gda_pkg::DefaultMaxYear
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [gda_pkg::DayW-1:0]  start_day,
  input  logic [gda_pkg::MonW-1:0]  start_month,
  input  logic [gda_pkg::YearW-1:0] start_year,
  input  logic signed [gda_pkg::OffW-1:0] day_offset,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [gda_pkg::DayW-1:0]  end_day,
  output logic [gda_pkg::MonW-1:0]  end_month,
  output logic [gda_pkg::YearW-1:0] end_year,
  output logic [gda_pkg::WdW-1:0]   weekday,
  output logic                    out_of_range
);
  import gda_pkg::*;

  localparam int Stages = 11;
  localparam int unsigned P = MAX_YEAR;
  localparam logic [SumW-1:0] Limit =
    SumW'(P * 365 + P / 4 - P / 100 + P / 400);
  // reciprocals, exact for years below 2^14 and day numbers below 2^25
  localparam logic [13:0] Recip100 = 14'd10486;
  localparam logic [25:0] Recip400 = 26'd60207212;

  logic en;
  logic [Stages-1:0] v;
  assign en = !out_stall;
  assign in_stall = out_stall;

  // stage 1: clamp month/year
  logic [MonW-1:0]  s1_m;
  logic [YearW-1:0] s1_y;
  logic [DayW-1:0]  s1_d;
  logic signed [OffW-1:0] s1_off;
  logic [YearW-1:0] y_cl;
  logic [MonW-1:0]  m_cl;
  always_comb begin
    y_cl = (start_year == '0) ? YearW'(1) : start_year;
    m_cl = (start_month == '0) ? 4'd1 : (start_month > 4'd12) ? 4'd12 : start_month;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_m <= m_cl; s1_y <= y_cl; s1_d <= start_day; s1_off <= day_offset;
    end
  end

  // stage 2: elapsed years divided by 100, day within year before leap day
  logic [YearW-1:0] p1;
  logic [27:0] p_mul;
  logic [YearW-1:0] s2_p;
  logic [7:0] s2_q100;
  logic signed [OffW:0] s2_part;
  logic s2_late;
  assign p1 = s1_y - YearW'(1);
  assign p_mul = 28'(p1) * 28'(Recip100);
  always_ff @(posedge clk) begin
    if (en) begin
      s2_p    <= p1;
      s2_q100 <= 8'(p_mul >> 20);
      s2_part <= (OffW+1)'(s1_off) + (OffW+1)'(days_before_month(s1_m))
               + (OffW+1)'(s1_d) - (OffW+1)'(1);
      s2_late <= s1_m > 4'd2;
    end
  end

  // stage 3: days before year, leap day of the start year
  logic [YearW-1:0] p_rem;
  logic in_leap;
  logic signed [SumW:0] s2_base;
  logic signed [OffW:0] s3_part;
  assign p_rem = s2_p - YearW'(s2_q100) * YearW'(100);
  // the year is a multiple of 4, 100 or 400 when the elapsed count leaves 3, 99, 399
  assign in_leap = (s2_p[1:0] == 2'd3 && p_rem != YearW'(99))
                || (p_rem == YearW'(99) && s2_q100[1:0] == 2'd3);
  always_ff @(posedge clk) begin
    if (en) begin
      s2_base <= (SumW+1)'(s2_p) * (SumW+1)'(365) + (SumW+1)'(s2_p >> 2)
               - (SumW+1)'(s2_q100) + (SumW+1)'(s2_q100 >> 2);
      s3_part <= s2_part + (OffW+1)'((s2_late && in_leap) ? 1 : 0);
    end
  end

  // stage 4: sum and range check
  logic signed [SumW+1:0] sum;
  logic [SumW-1:0] s3_s;
  logic s3_oor;
  assign sum = (SumW+2)'(s2_base) + (SumW+2)'(s3_part);
  always_ff @(posedge clk) begin
    if (en) begin
      s3_oor <= sum < 0 || sum >= (SumW+2)'(Limit);
      s3_s   <= sum[SumW-1:0];
    end
  end

  // stage 5: 400-year quotient by reciprocal; weekday from day number
  localparam int Q400W = 8;
  logic [51:0] q400_mul;
  logic [Q400W-1:0] s5_q400;
  logic [SumW-1:0] s5_s;
  logic [WdW-1:0] wd5, wd6, wd7, wd8, wd9, wd10;
  logic oor5, oor6, oor7, oor8, oor9, oor10;
  assign q400_mul = 52'(s3_s) * 52'(Recip400);
  always_ff @(posedge clk) begin
    if (en) begin
      s5_q400 <= Q400W'(q400_mul >> 43);
      s5_s    <= s3_s;
      wd5     <= mod7((SumW+1)'(s3_s) + (SumW+1)'(1));
      oor5    <= s3_oor;
    end
  end

  // stage 6: 400-year remainder
  logic [Q400W-1:0] q400;
  logic [17:0] r400;
  always_ff @(posedge clk) begin
    if (en) begin
      q400 <= s5_q400;
      r400 <= 18'(s5_s - SumW'(s5_q400) * SumW'(Days400));
      wd6  <= wd5;
      oor6 <= oor5;
    end
  end

  logic [1:0] q100; logic [17:0] r100;
  gda_split #(.Span(Days100), .MaxQ(3), .QW(2), .RW(18)) u_s100 (
    .clk(clk), .en(en), .r_in(r400), .q(q100), .r_out(r100));
  logic [4:0] q4; logic [17:0] r4;
  gda_split #(.Span(Days4), .MaxQ(24), .QW(5), .RW(18)) u_s4 (
    .clk(clk), .en(en), .r_in(r100), .q(q4), .r_out(r4));
  logic [1:0] q1; logic [17:0] r1;
  gda_split #(.Span(Days1), .MaxQ(3), .QW(2), .RW(18)) u_s1 (
    .clk(clk), .en(en), .r_in(r4), .q(q1), .r_out(r1));

  logic [Q400W-1:0] q400_7, q400_8, q400_9;
  logic [1:0] q100_8, q100_9;
  logic [4:0] q4_9;
  always_ff @(posedge clk) begin
    if (en) begin
      q400_7 <= q400; q400_8 <= q400_7; q400_9 <= q400_8;
      q100_8 <= q100; q100_9 <= q100_8; q4_9 <= q4;
      wd7 <= wd6; wd8 <= wd7; wd9 <= wd8;
      oor7 <= oor6; oor8 <= oor7; oor9 <= oor8;
    end
  end

  // stage 10: year and leap flag
  logic [16:0] yr_c, s10_yr;
  logic [8:0] s10_r;
  logic s10_leap;
  assign yr_c = 17'(q400_9) * 17'd400 + 17'(q100_9) * 17'd100 + 17'(q4_9) * 17'd4
              + 17'(q1) + 17'd1;
  always_ff @(posedge clk) begin
    if (en) begin
      s10_yr <= yr_c; s10_r <= r1[8:0];
      // leap when the last span of four years is full, except a non-fourth century end
      s10_leap <= (q1 == 2'd3) && (q4_9 != 5'd24 || q100_9 == 2'd3);
      wd10 <= wd9; oor10 <= oor9;
    end
  end

  // stage 11: month search over eleven independent compares
  logic [3:0] mo_c;
  logic [8:0] rd_c, mstart;
  always_comb begin
    mo_c = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      mstart = days_before_month(4'(k)) + ((k > 2 && s10_leap) ? 9'd1 : 9'd0);
      if (s10_r >= mstart) mo_c = 4'(k);
    end
    rd_c = s10_r - days_before_month(mo_c)
         - ((mo_c > 4'd2 && s10_leap) ? 9'd1 : 9'd0);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      end_day      <= oor10 ? '0 : DayW'(rd_c + 9'd1);
      end_month    <= oor10 ? '0 : mo_c;
      end_year     <= oor10 ? '0 : YearW'(s10_yr);
      weekday      <= oor10 ? '0 : wd10;
      out_of_range <= oor10;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[Stages-2:0], in_valid};
    end
  end
  assign out_valid = v[Stages-1];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(end_year))
    else $error("result changed under stall");
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> end_day == '0 && end_month == '0)
    else $error("out-of-range result not zeroed");
  a_month: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |-> end_month >= 4'd1 && end_month <= 4'd12
      && weekday <= 3'd6)
    else $error("month or weekday out of range");
endmodule

@@ sv/gda_split.sv @@
// One span-split pipeline stage: quotient and remainder of a day count by a
// constant span, quotient clamped to MaxQ. Depends on gda_pkg.
`timescale 1ns / 1ps
module gda_split #(
  parameter int Span = 365,
  parameter int MaxQ = 3,
  parameter int QW   = 2,
  parameter int RW   = 18
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] r_in,
  output logic [QW-1:0] q,
  output logic [RW-1:0] r_out
);
  import gda_pkg::*;
  logic [QW-1:0] q_c;
  logic [RW-1:0] r_c;

  // compare against each multiple: at most MaxQ steps, all independent
  always_comb begin
    q_c = '0;
    r_c = r_in;
    for (int i = 1; i <= MaxQ; i++) begin
      if (r_in >= RW'(i * Span)) begin
        q_c = QW'(i);
        r_c = r_in - RW'(i * Span);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q     <= q_c;
      r_out <= r_c;
    end
  end
endmodule
